### rtl/rv32_pkg.sv
// Package for the RV32IM executor: opcodes, constants and shared types.
// No dependencies.
`default_nettype none
package rv32_pkg;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;
    localparam logic [6:0] OP_AMO    = 7'b0101111;
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

    // Request to the serial multiply/divide unit.
    typedef enum logic [1:0] {
        MD_MUL, MD_DIV
    } t_md_kind;

    typedef struct packed {
        logic        start;
        t_md_kind    kind;
        logic [31:0] a;
        logic [31:0] b;
    } t_md_req;

    typedef struct packed {
        logic        done;
        logic [31:0] hi;
        logic [31:0] lo;
    } t_md_rsp;

    typedef struct packed {
        logic [31:0] executed_pc;
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic        store_done;
        logic [31:0] store_address;
        logic [31:0] store_data;
        logic [1:0]  store_size;
        logic        env_call;
        logic        unsupported;
    } t_result;
endpackage
`default_nettype wire

### rtl/rv32_if.sv
// Valid/ready channel interfaces for instruction, result and config.
// Depends on rv32_pkg.
`default_nettype none
interface rv32_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;
    modport source (output valid, output instruction_word, input ready);
    modport sink (input valid, input instruction_word, output ready);
endinterface

interface rv32_result_if;
    logic        valid;
    logic        ready;
    rv32_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rv32_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/rv32im_instruction_executor_core.sv
// Top level of the RV32IM executor: decode, register file, data memory, sequencer.
// Depends on rv32_pkg, rv32_if and rv32_muldiv.
`default_nettype none
// One instruction is taken at a time, and the input is ready again in the cycle after
// its result transaction is accepted. ALU, branch, jump, system and unrecognized
// words pass through register read, execute, result and idle. Stores move one byte
// per cycle through the data memory write port. Loads collect the bytes from the
// registered read and then pass a sign or zero extension step. Multiply and divide
// wait on the bit-serial unit (request, load, 32 steps). After reset the data memory
// is cleared one byte per cycle, during which no instruction is accepted; the
// configuration channel is always ready and loads the program counter too.
module rv32im_instruction_executor_core #(
    parameter int MEM_BYTES = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rv32_instr_if.sink  i_instr,
    rv32_result_if.source o_result,
    rv32_cfg_if.sink    i_cfg
);
    import rv32_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MEM, S_MD, S_MDFIX, S_DONE
    } t_state;

    t_state      r_state;
    logic [31:0] r_pc, r_start;
    logic [31:0] r_w, r_a, r_b;
    logic [31:0] r_regs [32];
    logic [7:0]  r_mem [MEM_BYTES];
    logic [AW-1:0] r_clr;
    logic [31:0] r_addr;
    logic [2:0]  r_bcnt, r_blen;
    logic        r_is_store;
    logic [31:0] r_ld;
    logic [7:0]  r_rd_byte;
    logic        r_rd_vld;
    logic        r_mem_wr;
    logic [AW-1:0] r_mem_wa;
    logic [7:0]  r_mem_wd;
    t_result     r_res;
    logic        r_neg_q, r_neg_r;
    t_md_req     r_md_req;
    t_md_rsp     w_md_rsp;

    logic [6:0]  w_op;
    logic [2:0]  w_f3;
    logic [6:0]  w_f7;
    logic [4:0]  w_rd;
    logic [31:0] w_imm_i, w_imm_s, w_imm_b, w_imm_j, w_opb;
    logic [4:0]  w_sh;
    logic        w_lt, w_ltu, w_take;
    logic [31:0] w_ma, w_mb;
    logic [AW-1:0] w_byte_addr;

    rv32_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_md_req),
        .o_rsp   (w_md_rsp)
    );

    // Field decode of the held instruction word.
    always_comb begin
        w_op = r_w[6:0];
        w_f3 = r_w[14:12];
        w_f7 = r_w[31:25];
        w_rd = r_w[11:7];
        w_imm_i = {{20{r_w[31]}}, r_w[31:20]};
        w_imm_s = {{20{r_w[31]}}, r_w[31:25], r_w[11:7]};
        w_imm_b = {{19{r_w[31]}}, r_w[31], r_w[7], r_w[30:25], r_w[11:8], 1'b0};
        w_imm_j = {{11{r_w[31]}}, r_w[31], r_w[19:12], r_w[20], r_w[30:21], 1'b0};
        // Only the immediate ALU group compares against the immediate.
        w_opb = (w_op == OP_IMM) ? w_imm_i : r_b;
        w_sh  = (w_op == OP_REG) ? r_b[4:0] : r_w[24:20];
        w_lt  = (r_a ^ SIGN_BIT) < (w_opb ^ SIGN_BIT);
        w_ltu = r_a < w_opb;
        case (w_f3)
            3'd0: w_take = (r_a == r_b);
            3'd1: w_take = (r_a != r_b);
            3'd4: w_take = w_lt;
            3'd5: w_take = !w_lt;
            3'd6: w_take = w_ltu;
            3'd7: w_take = !w_ltu;
            default: w_take = 1'b0;
        endcase
        // Signed operations run on magnitudes.
        w_ma = ((w_f3 == 3'd1 || w_f3 == 3'd2 || w_f3 == 3'd4 || w_f3 == 3'd6)
                && r_a[31]) ? (32'd0 - r_a) : r_a;
        w_mb = ((w_f3 == 3'd1 || w_f3 == 3'd4 || w_f3 == 3'd6) && r_b[31])
               ? (32'd0 - r_b) : r_b;
        w_byte_addr = r_addr[AW-1:0] + AW'(r_bcnt);
    end

    // Data memory: byte wide, one write and one read port, read data registered.
    always_ff @(posedge i_clk) begin
        if (r_mem_wr) begin
            r_mem[r_mem_wa] <= r_mem_wd;
        end
        r_rd_byte <= r_mem[w_byte_addr];
    end

    assign i_cfg.ready   = 1'b1;
    assign i_instr.ready = (r_state == S_IDLE);
    assign o_result.valid = (r_state == S_DONE);
    assign o_result.data  = r_res;

    // Sequencer with the register file and result registers.
    always_ff @(posedge i_clk) begin
        logic [31:0] v_val;
        logic [31:0] v_hi, v_lo;
        logic        v_wr;
        logic [1:0]  v_lane;
        t_state      n_state;
        logic [31:0] n_pc;
        t_result     n_res;
        t_md_req     n_md_req;
        logic        n_mem_wr;
        n_state  = r_state;
        n_pc     = r_pc;
        n_res    = r_res;
        n_md_req = r_md_req;
        n_md_req.start = 1'b0;
        n_mem_wr = 1'b0;
        v_val  = 32'd0;
        v_wr   = 1'b0;
        v_hi   = 32'd0;
        v_lo   = 32'd0;
        v_lane = r_bcnt[1:0] - 2'd1;
        if (!i_rst_n) begin
            n_state  = S_CLEAR;
            n_pc     = 32'd0;
            r_clr    <= '0;
            r_start  <= 32'd0;
            r_rd_vld <= 1'b0;
            for (int i = 0; i < 32; i++) begin
                r_regs[i] <= 32'd0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_start <= i_cfg.data;
                n_pc     = i_cfg.data;
            end
            case (r_state)
                S_CLEAR: begin
                    n_mem_wr = 1'b1;
                    r_mem_wa <= r_clr;
                    r_mem_wd <= 8'd0;
                    r_clr    <= r_clr + AW'(1);
                    if (r_clr == AW'(MEM_BYTES - 1)) begin
                        n_state = S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_instr.valid) begin
                        r_w     <= i_instr.instruction_word;
                        n_state = S_READ;
                    end
                end
                S_READ: begin
                    r_a <= r_regs[r_w[19:15]];
                    r_b <= r_regs[r_w[24:20]];
                    n_state = S_EXEC;
                end
                S_EXEC: begin
                    n_res = '0;
                    n_res.executed_pc = r_pc;
                    n_pc    = r_pc + 32'd4;
                    n_state = S_DONE;
                    r_bcnt  <= 3'd0;
                    r_ld    <= 32'd0;
                    r_rd_vld <= 1'b0;
                    case (w_op)
                        OP_IMM, OP_REG: begin
                            v_wr = 1'b1;
                            if (w_op == OP_REG && w_f7 == 7'd1) begin
                                n_md_req.start = 1'b1;
                                n_md_req.kind  = w_f3[2] ? MD_DIV : MD_MUL;
                                n_md_req.a = w_ma;
                                n_md_req.b = w_mb;
                                r_neg_q <= (w_f3 == 3'd4) ? (r_a[31] ^ r_b[31]) :
                                           (w_f3 == 3'd1) ? (r_a[31] ^ r_b[31]) :
                                           (w_f3 == 3'd2) ? r_a[31] : 1'b0;
                                r_neg_r <= (w_f3 == 3'd6) && r_a[31];
                                n_state = S_MD;
                                v_wr = 1'b0;
                            end else begin
                                case (w_f3)
                                    3'd0: v_val = (w_op == OP_REG && w_f7 == 7'h20)
                                                  ? r_a - r_b : r_a + w_opb;
                                    3'd1: v_val = r_a << w_sh;
                                    3'd2: v_val = {31'd0, w_lt};
                                    3'd3: v_val = {31'd0, w_ltu};
                                    3'd4: v_val = r_a ^ w_opb;
                                    3'd5: v_val = (w_f7 == 7'h20)
                                        ? 32'($signed(r_a) >>> w_sh) : r_a >> w_sh;
                                    3'd6: v_val = r_a | w_opb;
                                    default: v_val = r_a & w_opb;
                                endcase
                                if ((w_op == OP_REG && !(w_f7 == 7'd0 ||
                                     (w_f7 == 7'h20 && (w_f3 == 3'd0 || w_f3 == 3'd5))))
                                    || (w_op == OP_IMM && w_f3 == 3'd1 && w_f7 != 7'd0)
                                    || (w_op == OP_IMM && w_f3 == 3'd5 &&
                                        w_f7 != 7'd0 && w_f7 != 7'h20)) begin
                                    v_wr = 1'b0;
                                    n_res.unsupported = 1'b1;
                                end
                            end
                        end
                        OP_LOAD: begin
                            if (w_f3 == 3'd3 || w_f3 == 3'd6 || w_f3 == 3'd7) begin
                                n_res.unsupported = 1'b1;
                            end else begin
                                r_addr <= r_a + w_imm_i;
                                r_blen <= 3'd1 << w_f3[1:0];
                                r_is_store <= 1'b0;
                                n_state = S_MEM;
                            end
                        end
                        OP_STORE: begin
                            if (w_f3 > 3'd2) begin
                                n_res.unsupported = 1'b1;
                            end else begin
                                r_addr <= r_a + w_imm_s;
                                r_blen <= 3'd1 << w_f3[1:0];
                                r_is_store <= 1'b1;
                                n_res.store_done    = 1'b1;
                                n_res.store_address = r_a + w_imm_s;
                                n_res.store_data    = r_b;
                                n_res.store_size    = w_f3[1:0];
                                n_state = S_MEM;
                            end
                        end
                        OP_BRANCH: begin
                            if (w_f3 == 3'd2 || w_f3 == 3'd3) begin
                                n_res.unsupported = 1'b1;
                            end else if (w_take) begin
                                n_pc = r_pc + w_imm_b;
                            end
                        end
                        OP_JAL: begin
                            v_wr = 1'b1;
                            v_val = r_pc + 32'd4;
                            n_pc = r_pc + w_imm_j;
                        end
                        OP_JALR: begin
                            if (w_f3 != 3'd0) begin
                                n_res.unsupported = 1'b1;
                            end else begin
                                v_wr = 1'b1;
                                v_val = r_pc + 32'd4;
                                n_pc = (r_a + w_imm_i) & ~32'd1;
                            end
                        end
                        OP_LUI: begin
                            v_wr = 1'b1;
                            v_val = {r_w[31:12], 12'd0};
                        end
                        OP_AUIPC: begin
                            v_wr = 1'b1;
                            v_val = r_pc + {r_w[31:12], 12'd0};
                        end
                        OP_SYSTEM: begin
                            if (r_w == ECALL_WORD) begin
                                n_res.env_call = 1'b1;
                            end else begin
                                n_res.unsupported = 1'b1;
                            end
                        end
                        OP_AMO: begin
                            if (w_f3 == 3'd2 && r_w[31:27] == 5'd2) begin
                                r_addr <= r_a;
                                r_blen <= 3'd4;
                                r_is_store <= 1'b0;
                                n_state = S_MEM;
                            end else if (w_f3 == 3'd2 && r_w[31:27] == 5'd3) begin
                                r_addr <= r_a;
                                r_blen <= 3'd4;
                                r_is_store <= 1'b1;
                                n_res.store_done    = 1'b1;
                                n_res.store_address = r_a;
                                n_res.store_data    = r_b;
                                n_res.store_size    = 2'd2;
                                v_wr = 1'b1;
                                v_val = 32'd0;
                                n_state = S_MEM;
                            end else begin
                                n_res.unsupported = 1'b1;
                            end
                        end
                        default: n_res.unsupported = 1'b1;
                    endcase
                    n_res.next_pc = n_pc;
                    if (v_wr && w_rd != 5'd0) begin
                        r_regs[w_rd] <= v_val;
                        n_res.reg_written = 1'b1;
                        n_res.dest_index  = w_rd;
                        n_res.dest_value  = v_val;
                    end
                end
                S_MEM: begin
                    // Stores write one byte a cycle; loads collect the byte read
                    // in the cycle before.
                    if (r_is_store) begin
                        n_mem_wr = 1'b1;
                        r_mem_wa <= w_byte_addr;
                        r_mem_wd <= r_b[8*r_bcnt[1:0] +: 8];
                        r_bcnt   <= r_bcnt + 3'd1;
                        if (r_bcnt + 3'd1 == r_blen) begin
                            n_state = S_DONE;
                        end
                    end else begin
                        r_rd_vld <= 1'b1;
                        if (r_rd_vld) begin
                            r_ld[8*v_lane +: 8] <= r_rd_byte;
                        end
                        if (r_bcnt == r_blen) begin
                            n_state = S_MDFIX;
                        end else begin
                            r_bcnt <= r_bcnt + 3'd1;
                        end
                    end
                end
                S_MD: begin
                    if (w_md_rsp.done) begin
                        v_hi = w_md_rsp.hi;
                        v_lo = w_md_rsp.lo;
                        case (w_f3)
                            3'd0: v_val = v_lo;
                            3'd1, 3'd2: v_val = r_neg_q
                                ? (~v_hi + ((v_lo == 32'd0) ? 32'd1 : 32'd0)) : v_hi;
                            3'd3: v_val = v_hi;
                            3'd4: v_val = (r_b == 32'd0) ? 32'hFFFF_FFFF :
                                          (r_neg_q ? 32'd0 - v_lo : v_lo);
                            3'd5: v_val = v_lo;
                            3'd6: v_val = (r_b == 32'd0) ? r_a :
                                          (r_neg_r ? 32'd0 - v_hi : v_hi);
                            default: v_val = (r_b == 32'd0) ? r_a : v_hi;
                        endcase
                        if (w_rd != 5'd0) begin
                            r_regs[w_rd] <= v_val;
                            n_res.reg_written = 1'b1;
                            n_res.dest_index  = w_rd;
                            n_res.dest_value  = v_val;
                        end
                        n_state = S_DONE;
                    end
                end
                S_MDFIX: begin
                    // Load extension and write-back.
                    case (w_f3)
                        3'd0: v_val = {{24{r_ld[7]}}, r_ld[7:0]};
                        3'd1: v_val = {{16{r_ld[15]}}, r_ld[15:0]};
                        3'd4: v_val = {24'd0, r_ld[7:0]};
                        3'd5: v_val = {16'd0, r_ld[15:0]};
                        default: v_val = r_ld;
                    endcase
                    if (w_rd != 5'd0) begin
                        r_regs[w_rd] <= v_val;
                        n_res.reg_written = 1'b1;
                        n_res.dest_index  = w_rd;
                        n_res.dest_value  = v_val;
                    end
                    n_state = S_DONE;
                end
                S_DONE: begin
                    if (o_result.ready) begin
                        n_state = S_IDLE;
                    end
                end
                default: n_state = S_IDLE;
            endcase
        end
        r_state  <= n_state;
        r_pc     <= n_pc;
        r_res    <= n_res;
        r_md_req <= n_md_req;
        r_mem_wr <= n_mem_wr;
    end

`ifndef SYNTHESIS
    a_x0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_regs[0] == 32'd0)
        else $error("x0 is not zero");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_instr.ready)
        else $error("instruction accepted while busy");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.ready) |=> $stable(r_res))
        else $error("result changed while stalled");
    a_store_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && r_res.unsupported |-> !r_res.reg_written && !r_res.store_done)
        else $error("unsupported word changed state");
`endif
endmodule
`default_nettype wire

### rtl/rv32_muldiv.sv
// Bit-serial unsigned multiplier and restoring divider, one bit per cycle.
// Depends on rv32_pkg.
`default_nettype none
module rv32_muldiv (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  rv32_pkg::t_md_req i_req,
    output rv32_pkg::t_md_rsp o_rsp
);
    import rv32_pkg::*;

    logic        r_busy, n_busy;
    t_md_kind    r_kind, n_kind;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_hi, n_hi;
    logic [31:0] r_lo, n_lo;
    logic [31:0] r_b, n_b;
    logic        r_done, n_done;
    logic [32:0] w_add;
    logic [32:0] w_rem;
    logic [32:0] w_sub;

    // Operand load on a start, else while busy one shift-add or shift-subtract step on the hi:lo pair.
    always_comb begin
        w_add = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_b} : 33'd0);
        w_rem = {r_hi, r_lo[31]};
        w_sub = w_rem - {1'b0, r_b};
        n_busy = r_busy;
        n_kind = r_kind;
        n_cnt  = r_cnt;
        n_hi   = r_hi;
        n_lo   = r_lo;
        n_b    = r_b;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_kind = i_req.kind;
            n_cnt  = 6'd0;
            n_hi   = 32'd0;
            n_lo   = i_req.a;
            n_b    = i_req.b;
        end else if (r_busy) begin
            if (r_kind == MD_MUL) begin
                n_hi = w_add[32:1];
                n_lo = {w_add[0], r_lo[31:1]};
            end else if (!w_sub[32]) begin
                n_hi = w_sub[31:0];
                n_lo = {r_lo[30:0], 1'b1};
            end else begin
                n_hi = w_rem[31:0];
                n_lo = {r_lo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_kind <= n_kind;
        r_cnt  <= n_cnt;
        r_hi   <= n_hi;
        r_lo   <= n_lo;
        r_b    <= n_b;
    end

    assign o_rsp = '{done: r_done, hi: r_hi, lo: r_lo};
endmodule
`default_nettype wire

### tb/tb_rv32im_instruction_executor_core.sv
// Testbench for rv32im_instruction_executor_core: directed and random instruction streams
// checked against an in-bench model of the core's architectural state.
// Depends on rv32_pkg, rv32_if and the core RTL.
`timescale 1ns / 100ps
module tb_rv32im_instruction_executor_core;
    import rv32_pkg::*;

    localparam int MEM_SIZE = 4096;
    localparam int TX_COUNT = 1150;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;
    localparam int DRAIN_CYCLES = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rv32_instr_if  instr_ch();
    rv32_result_if result_ch();
    rv32_cfg_if    cfg_ch();

    rv32im_instruction_executor_core #(.MEM_BYTES(MEM_SIZE)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_instr(instr_ch.sink),
        .o_result(result_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Architectural state of the predictor.
    logic [31:0] arch_regs [32];
    logic [31:0] arch_pc;
    logic [7:0]  arch_mem [MEM_SIZE];
    t_result     pending_results [$];

    int  mismatch_count = 0;
    int  sent_count = 0;
    int  checked_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    longint cycle_count = 0;

    initial begin
        instr_ch.valid = 1'b0;
        instr_ch.instruction_word = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
    end

    function automatic logic [31:0] mem_load(logic [31:0] addr, int nbytes);
        logic [31:0] v;
        int base;
        v = '0;
        base = addr % MEM_SIZE;
        for (int i = 0; i < nbytes; i++)
            v[8*i +: 8] = arch_mem[(base + i) % MEM_SIZE];
        return v;
    endfunction

    task automatic mem_store(logic [31:0] addr, logic [31:0] d, int nbytes);
        int base;
        base = addr % MEM_SIZE;
        for (int i = 0; i < nbytes; i++)
            arch_mem[(base + i) % MEM_SIZE] = d[8*i +: 8];
    endtask

    function automatic logic [31:0] div_s(logic [31:0] a, logic [31:0] b, bit want_rem);
        if (b == 0) return want_rem ? a : 32'hFFFF_FFFF;
        if (a == SIGN_BIT && b == 32'hFFFF_FFFF) return want_rem ? 32'h0 : SIGN_BIT;
        return want_rem ? $unsigned($signed(a) % $signed(b))
                        : $unsigned($signed(a) / $signed(b));
    endfunction

    // Executes one instruction on the predictor and returns its result.
    task automatic execute_instruction(input logic [31:0] w, output t_result r);
        logic [6:0]  op;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [4:0]  rd;
        logic [31:0] a, b, pc, nxt, imm_i, imm_s, imm_b, imm_j, val, addr;
        logic [63:0] prod;
        bit wr, bad, take;
        op = w[6:0]; f3 = w[14:12]; f7 = w[31:25]; rd = w[11:7];
        a = arch_regs[w[19:15]]; b = arch_regs[w[24:20]];
        pc = arch_pc; nxt = pc + 4;
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        r = '0; wr = 0; bad = 0; val = 0;
        case (op)
            OP_IMM: begin
                wr = 1;
                case (f3)
                    3'd0: val = a + imm_i;
                    3'd2: val = {31'b0, $signed(a) < $signed(imm_i)};
                    3'd3: val = {31'b0, a < imm_i};
                    3'd4: val = a ^ imm_i;
                    3'd6: val = a | imm_i;
                    3'd7: val = a & imm_i;
                    3'd1: if (f7 == 0) val = a << w[24:20]; else bad = 1;
                    default: begin
                        if (f7 == 0) val = a >> w[24:20];
                        else if (f7 == 7'h20) val = $unsigned($signed(a) >>> w[24:20]);
                        else bad = 1;
                    end
                endcase
            end
            OP_REG: begin
                wr = 1;
                if (f7 == 0) begin
                    case (f3)
                        3'd0: val = a + b;
                        3'd1: val = a << b[4:0];
                        3'd2: val = {31'b0, $signed(a) < $signed(b)};
                        3'd3: val = {31'b0, a < b};
                        3'd4: val = a ^ b;
                        3'd5: val = a >> b[4:0];
                        3'd6: val = a | b;
                        default: val = a & b;
                    endcase
                end else if (f7 == 7'h20 && f3 == 0) begin
                    val = a - b;
                end else if (f7 == 7'h20 && f3 == 5) begin
                    val = $unsigned($signed(a) >>> b[4:0]);
                end else if (f7 == 7'h01) begin
                    case (f3)
                        3'd0: val = a * b;
                        3'd1: begin
                            prod = $unsigned($signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b}));
                            val = prod[63:32];
                        end
                        3'd2: begin
                            prod = {{32{a[31]}}, a} * {32'b0, b};
                            val = prod[63:32];
                        end
                        3'd3: begin
                            prod = {32'b0, a} * {32'b0, b};
                            val = prod[63:32];
                        end
                        3'd4: val = div_s(a, b, 0);
                        3'd5: val = (b == 0) ? 32'hFFFF_FFFF : a / b;
                        3'd6: val = div_s(a, b, 1);
                        default: val = (b == 0) ? a : a % b;
                    endcase
                end else bad = 1;
            end
            OP_LOAD: begin
                addr = a + imm_i;
                wr = 1;
                case (f3)
                    3'd0: begin val = mem_load(addr, 1); val = {{24{val[7]}}, val[7:0]}; end
                    3'd1: begin val = mem_load(addr, 2); val = {{16{val[15]}}, val[15:0]}; end
                    3'd2: val = mem_load(addr, 4);
                    3'd4: val = mem_load(addr, 1);
                    3'd5: val = mem_load(addr, 2);
                    default: bad = 1;
                endcase
            end
            OP_STORE: begin
                if (f3 <= 2) begin
                    r.store_done = 1;
                    r.store_address = a + imm_s;
                    r.store_data = b;
                    r.store_size = f3[1:0];
                    mem_store(a + imm_s, b, 1 << f3);
                end else bad = 1;
            end
            OP_BRANCH: begin
                case (f3)
                    3'd0: take = (a == b);
                    3'd1: take = (a != b);
                    3'd4: take = $signed(a) < $signed(b);
                    3'd5: take = !($signed(a) < $signed(b));
                    3'd6: take = a < b;
                    3'd7: take = a >= b;
                    default: begin take = 0; bad = 1; end
                endcase
                if (take) nxt = pc + imm_b;
            end
            OP_JAL: begin wr = 1; val = pc + 4; nxt = pc + imm_j; end
            OP_JALR: begin
                if (f3 == 0) begin
                    wr = 1; val = pc + 4; nxt = (a + imm_i) & ~32'd1;
                end else bad = 1;
            end
            OP_LUI: begin wr = 1; val = {w[31:12], 12'b0}; end
            OP_AUIPC: begin wr = 1; val = pc + {w[31:12], 12'b0}; end
            OP_SYSTEM: begin
                if (w == ECALL_WORD) r.env_call = 1; else bad = 1;
            end
            OP_AMO: begin
                if (f3 == 2 && w[31:27] == 5'd2) begin
                    wr = 1; val = mem_load(a, 4);
                end else if (f3 == 2 && w[31:27] == 5'd3) begin
                    r.store_done = 1; r.store_address = a; r.store_data = b;
                    r.store_size = 2'd2;
                    mem_store(a, b, 4);
                    wr = 1; val = 0;
                end else bad = 1;
            end
            default: bad = 1;
        endcase
        if (bad) wr = 0;
        if (wr && rd != 0) begin
            arch_regs[rd] = val;
        end else begin
            wr = 0; rd = 0; val = 0;
        end
        arch_pc = nxt;
        r.executed_pc = pc;
        r.next_pc = nxt;
        r.reg_written = wr;
        r.dest_index = rd;
        r.dest_value = val;
        r.unsupported = bad;
    endtask

    // Sends one instruction with the current idle rate, then predicts its result.
    // Valid stays high after the transaction until the next send or a drain drops it.
    task automatic send_instruction(input logic [31:0] w);
        t_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            instr_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        instr_ch.valid <= 1'b1;
        instr_ch.instruction_word <= w;
        @(posedge i_clk);
        while (!instr_ch.ready) @(posedge i_clk);
        execute_instruction(w, r);
        pending_results.push_back(r);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        instr_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Writes start_address while the core is idle.
    task automatic write_start_address(input logic [31:0] v);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        arch_pc = v;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result checker, one transaction per accepted result.
    always @(posedge i_clk) begin
        t_result exp_r, got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = result_ch.data;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result transaction: %h", got);
            end else begin
                exp_r = pending_results.pop_front();
                checked_count++;
                if (got !== exp_r) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch pc=%h: expected %p, actual %p",
                                 exp_r.executed_pc, exp_r, got);
                end
            end
        end
    end

    // Receiver stall driver.
    always @(negedge i_clk) begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAIL rv32im_instruction_executor_core");
            $finish;
        end
    end

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [6:0] op);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
    endfunction

    // Random instruction, mostly well-formed and weighted toward useful work.
    function automatic logic [31:0] random_instruction();
        logic [4:0] rd, rs1, rs2;
        logic [2:0] f3;
        logic [12:0] bimm;
        int pick;
        rd = $urandom_range(31); rs1 = $urandom_range(31); rs2 = $urandom_range(31);
        f3 = $urandom_range(7);
        pick = $urandom_range(99);
        if (pick < 20) begin
            if (f3 == 1) return enc_i({7'h0, 5'($urandom_range(31))}, rs1, f3, rd, OP_IMM);
            if (f3 == 5) return enc_i({$urandom_range(1) ? 7'h20 : 7'h0, 5'($urandom_range(31))},
                                      rs1, f3, rd, OP_IMM);
            return enc_i(12'($urandom), rs1, f3, rd, OP_IMM);
        end else if (pick < 35) begin
            return enc_r((f3 == 0 || f3 == 5) && $urandom_range(1) ? 7'h20 : 7'h0,
                         rs2, rs1, f3, rd, OP_REG);
        end else if (pick < 45) begin
            return enc_r(7'h01, rs2, rs1, f3, rd, OP_REG);
        end else if (pick < 50) begin
            return enc_i(12'($urandom), 5'd0, 3'd0, rd, OP_IMM);
        end else if (pick < 60) begin
            return enc_i(12'($urandom), rs1, 3'($urandom_range(5)), rd, OP_LOAD);
        end else if (pick < 70) begin
            return enc_s(12'($urandom), rs2, rs1, 3'($urandom_range(2)), OP_STORE);
        end else if (pick < 77) begin
            bimm = 13'($urandom) & ~13'd1;
            return {bimm[12], bimm[10:5], rs2, rs1, f3, bimm[4:1], bimm[11], OP_BRANCH};
        end else if (pick < 80) begin
            return {$urandom_range(1) ? 12'($urandom) : 12'h0, rs1, 3'd0, rd, OP_JALR};
        end else if (pick < 83) begin
            return {20'($urandom), rd, OP_JAL};
        end else if (pick < 88) begin
            return {20'($urandom), rd, $urandom_range(1) ? OP_LUI : OP_AUIPC};
        end else if (pick < 93) begin
            return {$urandom_range(1) ? 5'd2 : 5'd3, 2'($urandom), 5'(($urandom_range(1) == 0) ?
                    0 : rs2), rs1, 3'd2, rd, OP_AMO};
        end else if (pick < 95) begin
            return ECALL_WORD;
        end
        return $urandom;
    endfunction

    task automatic test_reset_defaults();
        send_instruction(enc_i(12'h7FF, 5'd0, 3'd0, 5'd1, OP_IMM));
        send_instruction(enc_i(12'h800, 5'd0, 3'd0, 5'd2, OP_IMM));
        send_instruction(enc_i(12'h004, 5'd0, 3'd2, 5'd3, OP_LOAD));
    endtask

    task automatic test_directed_alu_muldiv();
        send_instruction({20'h80000, 5'd4, OP_LUI});
        send_instruction(enc_i(12'hFFF, 5'd0, 3'd0, 5'd5, OP_IMM));
        send_instruction(enc_r(7'h01, 5'd5, 5'd4, 3'd4, 5'd6, OP_REG));
        send_instruction(enc_r(7'h01, 5'd5, 5'd4, 3'd6, 5'd7, OP_REG));
        send_instruction(enc_r(7'h01, 5'd0, 5'd4, 3'd4, 5'd8, OP_REG));
        send_instruction(enc_r(7'h01, 5'd0, 5'd4, 3'd7, 5'd9, OP_REG));
        send_instruction(enc_r(7'h01, 5'd5, 5'd4, 3'd1, 5'd10, OP_REG));
        send_instruction(enc_r(7'h01, 5'd5, 5'd5, 3'd3, 5'd11, OP_REG));
        send_instruction(enc_i({7'h20, 5'd31}, 5'd4, 3'd5, 5'd12, OP_IMM));
        send_instruction(enc_r(7'h20, 5'd5, 5'd4, 3'd0, 5'd0, OP_REG));
        send_instruction(enc_r(7'h7F, 5'd5, 5'd4, 3'd0, 5'd13, OP_REG));
    endtask

    task automatic test_memory_wrap_atomics();
        send_instruction(enc_s(12'hFFE, 5'd5, 5'd0, 3'd2, OP_STORE));
        send_instruction(enc_i(12'hFFF, 5'd0, 3'd1, 5'd14, OP_LOAD));
        send_instruction(enc_i(12'hFFE, 5'd0, 3'd4, 5'd15, OP_LOAD));
        send_instruction({5'd3, 2'b11, 5'd4, 5'd5, 3'd2, 5'd16, OP_AMO});
        send_instruction({5'd2, 2'b00, 5'd0, 5'd5, 3'd2, 5'd17, OP_AMO});
    endtask

    task automatic test_control_and_system();
        send_instruction(enc_i(12'h005, 5'd0, 3'd0, 5'd18, OP_JALR));
        send_instruction({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd19, OP_JAL});
        send_instruction({1'b0, 6'h0, 5'd0, 5'd0, 3'd0, 4'h3, 1'b0, OP_BRANCH});
        send_instruction({1'b0, 6'h0, 5'd0, 5'd0, 3'd2, 4'h3, 1'b0, OP_BRANCH});
        send_instruction({20'hFFFFF, 5'd20, OP_AUIPC});
        send_instruction(ECALL_WORD);
        send_instruction(32'h0010_0073);
        send_instruction(32'hFFFF_FFFF);
    endtask

    task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) send_instruction(random_instruction());
    endtask

    // Test sequence.
    initial begin
        for (int i = 0; i < 32; i++) arch_regs[i] = '0;
        for (int i = 0; i < MEM_SIZE; i++) arch_mem[i] = '0;
        arch_pc = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_alu_muldiv();
        test_memory_wrap_atomics();
        test_control_and_system();

        write_start_address(32'hFFFF_FFFC);
        test_random_phase(280, 0, 0);
        write_start_address(32'h0000_0000);
        test_random_phase(280, 84, 0);
        // Hold off until every result has come back.
        wait_drained();
        test_random_phase(280, 0, 84);
        write_start_address(32'h5A5A_A5A6);
        test_random_phase(280, 19, 19);

        wait_drained();
        $display("Ran %0d instructions, checked %0d results over four idle/stall phases",
                 sent_count, checked_count);
        $display("and three start addresses, with %0d mismatches.", mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS rv32im_instruction_executor_core");
        end else begin
            $display("FAIL rv32im_instruction_executor_core");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/rv32_pkg.sv
rtl/rv32_if.sv
rtl/rv32_muldiv.sv
rtl/rv32im_instruction_executor_core.sv
tb/tb_rv32im_instruction_executor_core.sv
